@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the chunk indexer checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define AMCI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define AMCI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/amci_pkg.sv @@
// ----------------------------------------------------------------------------
// amci_pkg
// types, constants and helpers shared by the movi chunk indexer modules
// ----------------------------------------------------------------------------
package amci_pkg;

    // default width of the running byte offset
    localparam int POS_WIDTH_DEF = 32;

    // depth of the event queue between parser and entry builder
    localparam int EVT_DEPTH = 4;

    // configuration reset values
    localparam logic [31:0] LIST_START_RST   = 32'd0;
    localparam logic [6:0]  VIDEO_STREAM_RST = 7'd0;
    localparam logic [6:0]  AUDIO_STREAM_RST = 7'd99;

    // tag and character constants
    localparam logic [31:0] TAG_LIST  = 32'h5453_494C;
    localparam logic [7:0]  CH_LO_D   = 8'h64;
    localparam logic [7:0]  CH_LO_B   = 8'h62;
    localparam logic [7:0]  CH_UP_B   = 8'h42;
    localparam logic [7:0]  CH_LO_C   = 8'h63;
    localparam logic [7:0]  CH_UP_C   = 8'h43;
    localparam logic [7:0]  CH_LO_W   = 8'h77;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [2:0]  HDR_LAST  = 3'd7;
    localparam logic [32:0] LIST_SKIP = 33'd4;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LIST_START   = 2'd0,
        CFG_VIDEO_STREAM = 2'd1,
        CFG_AUDIO_STREAM = 2'd2
    } t_cfg_idx;

    // entry kinds
    typedef enum logic {
        KIND_VIDEO = 1'b0,
        KIND_AUDIO = 1'b1
    } t_kind;

    // recognized chunk handed from parser to entry builder
    typedef struct packed {
        t_kind       kind;
        logic        clr;
        logic [31:0] tag;
        logic [31:0] size;
    } t_evt;

    // tens digit character of a stream number, n / 10 by reciprocal
    function automatic logic [7:0] tens_char(input logic [6:0] n);
        logic [17:0] prod;
        prod = 18'(n) * 18'd205;
        return CH_ZERO + 8'(prod >> 11);
    endfunction

    // ones digit character of a stream number
    function automatic logic [7:0] ones_char(input logic [6:0] n);
        logic [17:0] prod;
        logic [6:0]  q;
        logic [6:0]  rem;
        prod = 18'(n) * 18'd205;
        q    = 7'(prod >> 11);
        rem  = 7'(n - 7'(q * 7'd10));
        return CH_ZERO + 8'(rem);
    endfunction

endpackage

@@ rtl/amci_front.sv @@
// ----------------------------------------------------------------------------
// amci_front
// byte parser: gathers chunk headers, skips payloads, classifies tags
// ----------------------------------------------------------------------------
module amci_front #(
    parameter int POS_WIDTH = amci_pkg::POS_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first,
    input  logic [6:0]           i_video_stream,
    input  logic [6:0]           i_audio_stream,
    output logic                 o_evt_push,
    output amci_pkg::t_evt       o_evt,
    output logic [POS_WIDTH-1:0] o_pos1
);
    import amci_pkg::*;

    logic [2:0]           r_fill;
    logic [2:0]           n_fill;
    logic [7:0]           r_hdr [0:6];
    logic [32:0]          r_skip;
    logic [32:0]          n_skip;
    logic [POS_WIDTH-1:0] r_off;
    logic [POS_WIDTH-1:0] n_off;
    logic                 r_clr_pend;

    logic [2:0]           fill_c;
    logic [32:0]          skip_c;
    logic [POS_WIDTH-1:0] off_c;
    logic                 skipping;
    logic                 hdr_done;
    logic [31:0]          tag;
    logic [31:0]          size;
    logic                 is_list;
    logic                 video_hit;
    logic                 audio_hit;

    // a first byte sees the parser as freshly cleared
    always_comb begin
        fill_c   = i_first ? 3'd0 : r_fill;
        skip_c   = i_first ? 33'd0 : r_skip;
        off_c    = i_first ? '0 : r_off;
        skipping = (skip_c != 33'd0);
        hdr_done = !skipping && (fill_c == HDR_LAST);
        tag      = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
        size     = {i_data_byte, r_hdr[6], r_hdr[5], r_hdr[4]};
        n_off    = off_c + 1'b1;
    end

    // tag classification
    always_comb begin
        is_list   = (tag == TAG_LIST);
        video_hit = (tag[7:0] == tens_char(i_video_stream))
                 && (tag[15:8] == ones_char(i_video_stream))
                 && (tag[23:16] == CH_LO_D)
                 && ((tag[31:24] == CH_LO_B) || (tag[31:24] == CH_UP_B)
                  || (tag[31:24] == CH_LO_C) || (tag[31:24] == CH_UP_C));
        audio_hit = (tag[7:0] == tens_char(i_audio_stream))
                 && (tag[15:8] == ones_char(i_audio_stream))
                 && (tag[23:16] == CH_LO_W)
                 && (tag[31:24] == CH_LO_B);
    end

    // header fill and skip count
    always_comb begin
        n_fill = fill_c;
        n_skip = skip_c;
        if (skipping) begin
            n_skip = skip_c - 33'd1;
        end else if (hdr_done) begin
            n_fill = 3'd0;
            n_skip = is_list ? LIST_SKIP : ({1'b0, size} + 33'(size[0]));
        end else begin
            n_fill = fill_c + 3'd1;
        end
    end

    // event to the entry builder
    always_comb begin
        o_evt_push = i_accept && hdr_done && !is_list && (video_hit || audio_hit);
        o_evt.kind = video_hit ? KIND_VIDEO : KIND_AUDIO;
        o_evt.clr  = r_clr_pend || i_first;
        o_evt.tag  = tag;
        o_evt.size = size;
        o_pos1     = n_off;
    end

    // parser control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= 3'd0;
            r_skip     <= 33'd0;
            r_off      <= '0;
            r_clr_pend <= 1'b0;
        end else if (i_accept) begin
            r_fill     <= n_fill;
            r_skip     <= n_skip;
            r_off      <= n_off;
            r_clr_pend <= o_evt_push ? 1'b0 : (r_clr_pend || i_first);
        end
    end

    // header byte store
    always_ff @(posedge i_clk) begin
        if (i_accept && !skipping && !hdr_done) begin
            r_hdr[fill_c] <= i_data_byte;
        end
    end

endmodule

@@ rtl/amci_evt_q.sv @@
// ----------------------------------------------------------------------------
// amci_evt_q
// small first-in first-out queue for recognized chunk events
// ----------------------------------------------------------------------------
module amci_evt_q #(
    parameter int WIDTH = 64,
    parameter int DEPTH = amci_pkg::EVT_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    import amci_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    // queue status
    always_comb begin
        o_full  = (r_cnt == CW'(DEPTH));
        o_empty = (r_cnt == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_rdata = r_mem[r_rd];
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

@@ rtl/amci_back.sv @@
// ----------------------------------------------------------------------------
// amci_back
// entry builder: numbers entries, sums audio bytes, holds the result beat
// ----------------------------------------------------------------------------
module amci_back #(
    parameter int POS_WIDTH = amci_pkg::POS_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_evt_valid,
    input  amci_pkg::t_evt       i_evt,
    input  logic [POS_WIDTH-1:0] i_pos1,
    input  logic [31:0]          i_list_start,
    input  logic                 i_pop,
    output logic                 o_evt_take,
    output logic                 o_empty,
    output logic                 o_stream_kind,
    output logic [31:0]          o_chunk_tag,
    output logic [31:0]          o_payload_pos,
    output logic [31:0]          o_chunk_length,
    output logic [31:0]          o_entry_number,
    output logic [31:0]          o_audio_bytes_before
);
    import amci_pkg::*;

    logic                 r_valid;
    logic [31:0]          r_video_cnt;
    logic [31:0]          r_audio_cnt;
    logic [31:0]          r_audio_total;
    logic [31:0]          video_c;
    logic [31:0]          audio_c;
    logic [31:0]          total_c;
    logic [POS_WIDTH-1:0] pos_sum;
    logic                 r_kind;
    logic [31:0]          r_tag;
    logic [31:0]          r_pos;
    logic [31:0]          r_len;
    logic [31:0]          r_num;
    logic [31:0]          r_before;

    // counters as this event sees them, cleared by a new scan
    always_comb begin
        o_evt_take = i_evt_valid && (!r_valid || i_pop);
        video_c    = i_evt.clr ? 32'd0 : r_video_cnt;
        audio_c    = i_evt.clr ? 32'd0 : r_audio_cnt;
        total_c    = i_evt.clr ? 32'd0 : r_audio_total;
        pos_sum    = POS_WIDTH'(i_list_start) + i_pos1;
    end

    // running counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_cnt   <= 32'd0;
            r_audio_cnt   <= 32'd0;
            r_audio_total <= 32'd0;
        end else if (o_evt_take) begin
            if (i_evt.kind == KIND_VIDEO) begin
                r_video_cnt   <= video_c + 32'd1;
                r_audio_cnt   <= audio_c;
                r_audio_total <= total_c;
            end else begin
                r_video_cnt   <= video_c;
                r_audio_cnt   <= audio_c + 32'd1;
                r_audio_total <= total_c + i_evt.size;
            end
        end
    end

    // result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_evt_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (o_evt_take) begin
            r_kind   <= i_evt.kind;
            r_tag    <= i_evt.tag;
            r_pos    <= 32'(pos_sum);
            r_len    <= i_evt.size;
            r_num    <= (i_evt.kind == KIND_VIDEO) ? video_c : audio_c;
            r_before <= total_c;
        end
    end

    assign o_empty              = !r_valid;
    assign o_stream_kind        = r_kind;
    assign o_chunk_tag          = r_tag;
    assign o_payload_pos        = r_pos;
    assign o_chunk_length       = r_len;
    assign o_entry_number       = r_num;
    assign o_audio_bytes_before = r_before;

endmodule

@@ rtl/avi_movi_chunk_indexer_unit.sv @@
// ----------------------------------------------------------------------------
// avi_movi_chunk_indexer_unit
// scans movi list bytes and emits one index entry per selected video or audio chunk
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  -------   --------------   ------------------------------------------------
//  input     push / full      i_data_byte, i_first
//  result    empty / pop      o_stream_kind, o_chunk_tag, o_payload_pos,
//                             o_chunk_length, o_entry_number,
//                             o_audio_bytes_before
//  config    i_cfg_we         i_cfg_idx, i_cfg_data
//
//  one byte per clock while full is low; the edge that takes a header's last
//  byte writes the event queue; the result register loads from its head when free
//  the event queue (four deep) and the result register decouple the parser
//  from the result side; full rises only when the event queue is full
//  synchronous active-low reset clears parser and counters and resets configuration
// ----------------------------------------------------------------------------
module avi_movi_chunk_indexer_unit #(
    parameter int POS_WIDTH = amci_pkg::POS_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        o_stream_kind,
    output logic [31:0] o_chunk_tag,
    output logic [31:0] o_payload_pos,
    output logic [31:0] o_chunk_length,
    output logic [31:0] o_entry_number,
    output logic [31:0] o_audio_bytes_before,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import amci_pkg::*;

    localparam int EVT_W = $bits(t_evt);
    localparam int Q_W   = EVT_W + POS_WIDTH;

    logic [31:0]          r_list_start;
    logic [6:0]           r_video_stream;
    logic [6:0]           r_audio_stream;

    logic                 in_accept;
    logic                 evt_push;
    t_evt                 evt_in;
    logic [POS_WIDTH-1:0] pos1_in;
    logic [Q_W-1:0]       q_rdata;
    logic                 q_empty;
    logic                 evt_take;
    t_evt                 evt_out;
    logic [POS_WIDTH-1:0] pos1_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_start   <= LIST_START_RST;
            r_video_stream <= VIDEO_STREAM_RST;
            r_audio_stream <= AUDIO_STREAM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LIST_START:   r_list_start   <= i_cfg_data;
                CFG_VIDEO_STREAM: r_video_stream <= i_cfg_data[6:0];
                CFG_AUDIO_STREAM: r_audio_stream <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign in_accept = push && !full;

    // byte parser
    amci_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_data_byte    (i_data_byte),
        .i_first        (i_first),
        .i_video_stream (r_video_stream),
        .i_audio_stream (r_audio_stream),
        .o_evt_push     (evt_push),
        .o_evt          (evt_in),
        .o_pos1         (pos1_in)
    );

    // event queue
    amci_evt_q #(
        .WIDTH (Q_W),
        .DEPTH (EVT_DEPTH)
    ) u_evt_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_push),
        .i_wdata ({pos1_in, evt_in}),
        .i_pop   (evt_take),
        .o_rdata (q_rdata),
        .o_full  (full),
        .o_empty (q_empty)
    );

    assign evt_out  = t_evt'(q_rdata[EVT_W-1:0]);
    assign pos1_out = q_rdata[Q_W-1:EVT_W];

    // entry builder
    amci_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_evt_valid          (!q_empty),
        .i_evt                (evt_out),
        .i_pos1               (pos1_out),
        .i_list_start         (r_list_start),
        .i_pop                (pop),
        .o_evt_take           (evt_take),
        .o_empty              (empty),
        .o_stream_kind        (o_stream_kind),
        .o_chunk_tag          (o_chunk_tag),
        .o_payload_pos        (o_payload_pos),
        .o_chunk_length       (o_chunk_length),
        .o_entry_number       (o_entry_number),
        .o_audio_bytes_before (o_audio_bytes_before)
    );

endmodule

@@ rtl/amci_checker.sv @@
// ----------------------------------------------------------------------------
// amci_checker
// port-level checks on the chunk indexer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module amci_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_stream_kind,
    input logic [31:0] o_chunk_tag
);
    import amci_pkg::*;

    // out of reset the result side is empty and the event queue is not full
    `AMCI_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (empty && !full), "not idle after reset")

    // a waiting result beat holds until taken
    `AMCI_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_chunk_tag)), "result beat dropped or changed")

    // audio entries carry the wb suffix
    `AMCI_ASSERT(a_audio_tag, i_clk, i_rst_n, (!empty && o_stream_kind) |-> ((o_chunk_tag[23:16] == CH_LO_W) && (o_chunk_tag[31:24] == CH_LO_B)), "audio entry with bad tag")

    // video entries carry the d marker
    `AMCI_ASSERT(a_video_tag, i_clk, i_rst_n, (!empty && !o_stream_kind) |-> (o_chunk_tag[23:16] == CH_LO_D), "video entry with bad tag")

endmodule

bind avi_movi_chunk_indexer_unit amci_checker u_amci_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_stream_kind (o_stream_kind),
    .o_chunk_tag   (o_chunk_tag)
);
